FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent holds, consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Types and constants shared by the pan/tilt approach block.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_UPDATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_SYNC    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEU_YAW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEU_PITCH = 3'd4;

	localparam int RATE_W   = 16;
	localparam int THRESH_W = 16;
	localparam int SPEED_W  = 10;
	localparam int STEP_W   = 16;

	localparam logic [RATE_W-1:0]   RATE_RESET   = 16'd1024;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd64;
	localparam logic [SPEED_W-1:0]  SPEED_RESET  = 10'd180;

	// Time step in 1/65536 s: default 0.02 s, ceiling 0.2 s.
	localparam int DT_W = 14;
	localparam logic [DT_W-1:0] DT_DEFAULT = 14'd1311;
	localparam logic [DT_W-1:0] DT_MAX     = 14'd13107;

	// Gain in Q1.16, saturated at one.
	localparam int GAIN_SHIFT = 8;
	localparam int GSH_W      = RATE_W + DT_W - GAIN_SHIFT;
	localparam int GAIN_W     = 17;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

	localparam int FRAC_W     = 16;
	localparam int ROUND_HALF = 32768;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL_Y  = 5'b00010,
		ST_MUL_P  = 5'b00100,
		ST_ADJ_P  = 5'b01000,
		ST_FINISH = 5'b10000
	} pte_state_t;

	typedef struct packed {
		logic load;
		logic mul_y;
		logic mul_p;
		logic adj_p;
		logic commit;
	} pte_cmd_t;

	typedef struct packed {
		logic arith;
	} pte_stat_t;

endpackage

FILE: src/pte_in_if.sv
// ----------------------------------------------------------------------------
// pte_in_if
// Input channel: one op with target or measured pose and time step.
// ----------------------------------------------------------------------------
interface pte_in_if #(parameter int ANGLE_BITS = 16) ();
	import pte_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [OP_W-1:0]              op;
	logic signed [ANGLE_BITS-1:0] yaw_in;
	logic signed [ANGLE_BITS-1:0] pitch_in;
	logic                         yaw_ok;
	logic                         pitch_ok;
	logic [STEP_W-1:0]            step_time;
	logic                         step_ok;

	modport source (output valid, op, yaw_in, pitch_in, yaw_ok, pitch_ok, step_time,
		step_ok, input ready);
	modport sink (input valid, op, yaw_in, pitch_in, yaw_ok, pitch_ok, step_time,
		step_ok, output ready);
endinterface

FILE: src/pte_out_if.sv
// ----------------------------------------------------------------------------
// pte_out_if
// Output channel: one servo command beat.
// ----------------------------------------------------------------------------
interface pte_out_if #(parameter int ANGLE_BITS = 16) ();
	import pte_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         cmd_valid;
	logic signed [ANGLE_BITS-1:0] cmd_yaw;
	logic signed [ANGLE_BITS-1:0] cmd_pitch;
	logic [SPEED_W-1:0]           cmd_speed;
	logic                         arrived;

	modport source (output valid, cmd_valid, cmd_yaw, cmd_pitch, cmd_speed, arrived,
		input ready);
	modport sink (input valid, cmd_valid, cmd_yaw, cmd_pitch, cmd_speed, arrived,
		output ready);
endinterface

FILE: src/pan_tilt_exponential_approach.sv
// A valid update runs as follows from the accepting beat until the next item
// can be taken: the item is latched with its gain and both axis errors, then
// a single shared multiplier scales the yaw error and the pitch error in turn,
// the pitch pose is adjusted, and the command is committed and shown as an
// output beat. Sync, restart, unused ops and updates with an invalid target
// skip the multiplier and go straight to the commit. One item is in flight at
// a time; a new item is accepted while the previous output beat still waits,
// and the commit of that item waits only for the output beat to be taken.
// ----------------------------------------------------------------------------
// pan_tilt_exponential_approach
// Yaw/pitch head pose follower that approaches a target exponentially.
// ----------------------------------------------------------------------------
//
// Angles are signed 1/64 degree, ANGLE_BITS wide; time steps are 1/65536 s.
// On an update the step is defaulted to 0.02 s when missing or zero and
// clamped to 0.2 s; the gain is approach_rate times the step in Q1.16,
// saturated at one, and each axis moves by the rounded fraction of its error.
// Arrival is flagged when the summed absolute error falls below the
// threshold. A sync loads the valid measured axes and flags arrival; a
// restart loads the neutral pose and clears the command valid flag.
//
// Configuration writes take effect at the clock edge where cfg_we is high
// and are meant to be issued while the block is idle. Register indexes:
// approach rate, arrival threshold, speed limit, neutral yaw, neutral pitch.
// Writes to other indexes are dropped. There is no read-back.
module pan_tilt_exponential_approach #(
	parameter int  ANGLE_BITS = 16,
	localparam int CFG_W      = (ANGLE_BITS > 16) ? ANGLE_BITS : 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pte_in_if.sink                        in_ch,
	pte_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [pte_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]              cfg_data
);
	import pte_pkg::*;

	pte_cmd_t  cmd;
	pte_stat_t stat;

	// The controller sequences the item and owns both handshakes.
	pte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the configuration and pose state; its command
	// registers drive the output payload directly.
	pte_dp #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.op        (in_ch.op),
		.yaw_in    (in_ch.yaw_in),
		.pitch_in  (in_ch.pitch_in),
		.yaw_ok    (in_ch.yaw_ok),
		.pitch_ok  (in_ch.pitch_ok),
		.step_time (in_ch.step_time),
		.step_ok   (in_ch.step_ok),
		.cmd_valid (out_ch.cmd_valid),
		.cmd_yaw   (out_ch.cmd_yaw),
		.cmd_pitch (out_ch.cmd_pitch),
		.cmd_speed (out_ch.cmd_speed),
		.arrived   (out_ch.arrived)
	);

endmodule

FILE: src/pte_ctrl.sv
// ----------------------------------------------------------------------------
// pte_ctrl
// Sequencer for the approach datapath and owner of the output beat flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pte_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pte_pkg::pte_stat_t  stat,
	output pte_pkg::pte_cmd_t   cmd
);
	import pte_pkg::*;

	pte_state_t state_q, state_d;
	logic       ovalid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.arith ? ST_MUL_Y : ST_FINISH;
				end
			end
			ST_MUL_Y: begin
				cmd.mul_y = 1'b1;
				state_d   = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.mul_p = 1'b1;
				state_d   = ST_ADJ_P;
			end
			ST_ADJ_P: begin
				cmd.adj_p = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				// The command registers feed the output directly, so they
				// change only once the previous beat has gone.
				if (!ovalid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_NEXT(a_mul_order, clk, arst_n, state_q == ST_MUL_Y, state_q == ST_MUL_P)
	`ASSERT_NEXT(a_commit_beat, clk, arst_n, cmd.commit, ovalid_q && in_ready)

endmodule

FILE: src/pte_dp.sv
// ----------------------------------------------------------------------------
// pte_dp
// Datapath: configuration, pose state, gain, shared multiplier, arrival test.
// ----------------------------------------------------------------------------
module pte_dp #(
	parameter int  ANGLE_BITS = 16,
	localparam int CFG_W      = (ANGLE_BITS > 16) ? ANGLE_BITS : 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pte_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]                    cfg_data,
	input  pte_pkg::pte_cmd_t                   cmd,
	output pte_pkg::pte_stat_t                  stat,
	input  logic [pte_pkg::OP_W-1:0]            op,
	input  logic signed [ANGLE_BITS-1:0]        yaw_in,
	input  logic signed [ANGLE_BITS-1:0]        pitch_in,
	input  logic                                yaw_ok,
	input  logic                                pitch_ok,
	input  logic [pte_pkg::STEP_W-1:0]          step_time,
	input  logic                                step_ok,
	output logic                                cmd_valid,
	output logic signed [ANGLE_BITS-1:0]        cmd_yaw,
	output logic signed [ANGLE_BITS-1:0]        cmd_pitch,
	output logic [pte_pkg::SPEED_W-1:0]         cmd_speed,
	output logic                                arrived
);
	import pte_pkg::*;

	localparam int DW = ANGLE_BITS + 1;
	localparam int PW = GAIN_W + 1 + DW;
	localparam int EW = (ANGLE_BITS + 2 > THRESH_W) ? ANGLE_BITS + 2 : THRESH_W;

	// Configuration registers.
	logic [RATE_W-1:0]            rate_q;
	logic [THRESH_W-1:0]          thresh_q;
	logic [SPEED_W-1:0]           speed_q;
	logic signed [ANGLE_BITS-1:0] neu_yaw_q, neu_pitch_q;

	// Latched item.
	logic [OP_W-1:0]              op_q;
	logic signed [ANGLE_BITS-1:0] tyaw_q, tpitch_q;
	logic                         yok_q, pok_q;
	logic [GAIN_W-1:0]            k_q;
	logic signed [DW-1:0]         dyaw_q, dpitch_q;
	logic signed [PW-1:0]         prod_q;

	// Pose and command state.
	logic signed [ANGLE_BITS-1:0] pose_yaw_q, pose_pitch_q, out_yaw_q, out_pitch_q;
	logic                         out_valid_q, at_target_q;
	logic [SPEED_W-1:0]           out_speed_q;

	logic [DT_W-1:0]              dt;
	logic [RATE_W+DT_W-1:0]       gain_full;
	logic [GSH_W-1:0]             gain_sh;
	logic [GAIN_W-1:0]            k;
	logic signed [DW-1:0]         dyaw, dpitch, mul_src;
	logic signed [PW-1:0]         mul_full, rnd, rnd_sh;
	logic signed [ANGLE_BITS+1:0] step_v, pose_ext, pose_sum;
	logic signed [ANGLE_BITS-1:0] pose_sel, adj_pose;
	logic signed [DW-1:0]         ey, ep;
	logic [DW-1:0]                aey, aep;
	logic [EW-1:0]                err_sum;
	logic                         near;

	assign stat.arith = (op == OP_UPDATE) && yaw_ok && pitch_ok;

	always_comb begin
		if (!step_ok || (step_time == '0)) begin
			dt = DT_DEFAULT;
		end else if (step_time > STEP_W'(DT_MAX)) begin
			dt = DT_MAX;
		end else begin
			dt = step_time[DT_W-1:0];
		end
	end

	assign gain_full = (RATE_W+DT_W)'(rate_q) * (RATE_W+DT_W)'(dt);
	assign gain_sh   = gain_full[RATE_W+DT_W-1:GAIN_SHIFT];
	assign k         = (gain_sh > GSH_W'(GAIN_ONE)) ? GAIN_ONE : gain_sh[GAIN_W-1:0];

	assign dyaw   = {yaw_in[ANGLE_BITS-1], yaw_in} - {pose_yaw_q[ANGLE_BITS-1], pose_yaw_q};
	assign dpitch = {pitch_in[ANGLE_BITS-1], pitch_in}
		- {pose_pitch_q[ANGLE_BITS-1], pose_pitch_q};

	// One multiplier serves both axes in turn.
	assign mul_src  = cmd.mul_p ? dpitch_q : dyaw_q;
	assign mul_full = PW'($signed({1'b0, k_q})) * PW'(mul_src);

	// Round to nearest with ties upward, then floor by the arithmetic shift.
	assign rnd      = prod_q + PW'(ROUND_HALF);
	assign rnd_sh   = rnd >>> FRAC_W;
	assign step_v   = rnd_sh[ANGLE_BITS+1:0];
	assign pose_sel = cmd.adj_p ? pose_pitch_q : pose_yaw_q;
	assign pose_ext = {pose_sel[ANGLE_BITS-1], pose_sel[ANGLE_BITS-1], pose_sel};
	assign pose_sum = pose_ext + step_v;
	assign adj_pose = pose_sum[ANGLE_BITS-1:0];

	assign ey      = {tyaw_q[ANGLE_BITS-1], tyaw_q} - {pose_yaw_q[ANGLE_BITS-1], pose_yaw_q};
	assign ep      = {tpitch_q[ANGLE_BITS-1], tpitch_q}
		- {pose_pitch_q[ANGLE_BITS-1], pose_pitch_q};
	assign aey     = ey[DW-1] ? DW'(-ey) : DW'(ey);
	assign aep     = ep[DW-1] ? DW'(-ep) : DW'(ep);
	assign err_sum = EW'(aey) + EW'(aep);
	assign near    = err_sum < EW'(thresh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= RATE_RESET;
			thresh_q    <= THRESH_RESET;
			speed_q     <= SPEED_RESET;
			neu_yaw_q   <= '0;
			neu_pitch_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RATE:      rate_q      <= cfg_data[RATE_W-1:0];
				REG_THRESH:    thresh_q    <= cfg_data[THRESH_W-1:0];
				REG_SPEED:     speed_q     <= cfg_data[SPEED_W-1:0];
				REG_NEU_YAW:   neu_yaw_q   <= cfg_data[ANGLE_BITS-1:0];
				REG_NEU_PITCH: neu_pitch_q <= cfg_data[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			tyaw_q   <= yaw_in;
			tpitch_q <= pitch_in;
			yok_q    <= yaw_ok;
			pok_q    <= pitch_ok;
			k_q      <= k;
			dyaw_q   <= dyaw;
			dpitch_q <= dpitch;
		end
		if (cmd.mul_y || cmd.mul_p) begin
			prod_q <= mul_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_yaw_q   <= '0;
			pose_pitch_q <= '0;
			out_yaw_q    <= '0;
			out_pitch_q  <= '0;
			out_valid_q  <= 1'b0;
			out_speed_q  <= SPEED_RESET;
			at_target_q  <= 1'b0;
		end else begin
			if (cmd.mul_p) begin
				pose_yaw_q <= adj_pose;
			end
			if (cmd.adj_p) begin
				pose_pitch_q <= adj_pose;
			end
			if (cmd.commit) begin
				case (op_q)
					OP_UPDATE: begin
						if (yok_q && pok_q) begin
							at_target_q <= near;
							out_valid_q <= 1'b1;
							out_yaw_q   <= pose_yaw_q;
							out_pitch_q <= pose_pitch_q;
							out_speed_q <= speed_q;
						end else begin
							out_valid_q <= 1'b0;
						end
					end
					OP_SYNC: begin
						if (yok_q) begin
							pose_yaw_q <= tyaw_q;
						end
						if (pok_q) begin
							pose_pitch_q <= tpitch_q;
						end
						out_yaw_q   <= yok_q ? tyaw_q : pose_yaw_q;
						out_pitch_q <= pok_q ? tpitch_q : pose_pitch_q;
						at_target_q <= 1'b1;
					end
					OP_RESTART: begin
						pose_yaw_q   <= neu_yaw_q;
						pose_pitch_q <= neu_pitch_q;
						out_yaw_q    <= neu_yaw_q;
						out_pitch_q  <= neu_pitch_q;
						out_valid_q  <= 1'b0;
						at_target_q  <= 1'b0;
						out_speed_q  <= speed_q;
					end
					default: ;
				endcase
			end
		end
	end

	assign cmd_valid = out_valid_q;
	assign cmd_yaw   = out_yaw_q;
	assign cmd_pitch = out_pitch_q;
	assign cmd_speed = out_speed_q;
	assign arrived   = at_target_q;

endmodule
